### rtl/core/dltc_pkg.sv
package dltc_pkg;

    // configuration port
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    typedef enum logic [1:0] {
        REG_ACTIVE_LANES = 2'd0,
        REG_DRIVE_TABLE  = 2'd1,
        REG_TPS3_ENABLE  = 2'd2
    } t_reg_idx;

    // register reset values
    localparam logic [2:0] ACTIVE_LANES_RST = 3'd4;
    localparam logic       DRIVE_TABLE_RST  = 1'b1;
    localparam logic       TPS3_ENABLE_RST  = 1'b0;

    // request kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_POLL  = 1'b1;

    // training patterns
    localparam logic [1:0] PAT_OFF = 2'd0;
    localparam logic [1:0] PAT_1   = 2'd1;
    localparam logic [1:0] PAT_2   = 2'd2;
    localparam logic [1:0] PAT_3   = 2'd3;

    // status codes
    localparam logic [1:0] STAT_IDLE  = 2'd0;
    localparam logic [1:0] STAT_TRAIN = 2'd1;
    localparam logic [1:0] STAT_PASS  = 2'd2;
    localparam logic [1:0] STAT_FAIL  = 2'd3;

    // lane status masks
    localparam logic [15:0] CR_MASK_1 = 16'h0001;
    localparam logic [15:0] CR_MASK_2 = 16'h0011;
    localparam logic [15:0] CR_MASK_4 = 16'h1111;
    localparam logic [15:0] EQ_MASK_1 = 16'h0007;
    localparam logic [15:0] EQ_MASK_2 = 16'h0077;
    localparam logic [15:0] EQ_MASK_4 = 16'h7777;

    // retry limits
    localparam logic [2:0] REPEAT_LIMIT = 3'd4;
    localparam logic [2:0] EQ_TRY_LIMIT = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_CR   = 3'd1,
        PH_EQ   = 3'd2,
        PH_PASS = 3'd3,
        PH_FAIL = 3'd4
    } t_phase;

    typedef struct packed {
        logic        kind;
        logic [15:0] lane_flags;
        logic [15:0] adjust_request;
        logic        align_ok;
    } t_in_item;

    typedef struct packed {
        logic [5:0] lane_set;
        logic       drive_valid;
        logic [3:0] drive_select;
        logic [1:0] pattern;
        logic [1:0] status;
    } t_out_item;

    typedef struct packed {
        logic [1:0] swing;
        logic [1:0] emph;
    } t_levels;

    typedef struct packed {
        logic       valid;
        logic [3:0] sel;
    } t_drive;

    // swing limit by emphasis, per table
    function automatic logic [1:0] swing_clamp(input logic dt, input logic [1:0] e);
        logic [1:0] c;
        case ({dt, e})
            3'd0:    c = 2'd3;
            3'd1:    c = 2'd2;
            3'd2:    c = 2'd1;
            3'd3:    c = 2'd0;
            3'd4:    c = 2'd2;
            3'd5:    c = 2'd2;
            3'd6:    c = 2'd1;
            default: c = 2'd0;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] swing_limit(input logic dt);
        return dt ? 2'd2 : 2'd3;
    endfunction

    function automatic logic [1:0] emph_limit(input logic dt);
        return (dt == 1'b0) ? 2'd3 : 2'd3;
    endfunction

    // all active lanes show the masked bits; lane counts other than 1, 2 and 4 check nothing
    function automatic logic lanes_match(input logic [2:0] lc, input logic [15:0] st,
                                         input logic [15:0] m1, input logic [15:0] m2,
                                         input logic [15:0] m4);
        logic ok;
        case (lc)
            3'd1:    ok = ((st & m1) == m1);
            3'd2:    ok = ((st & m2) == m2);
            3'd4:    ok = ((st & m4) == m4);
            default: ok = 1'b1;
        endcase
        return ok;
    endfunction

    // maximum of the request over lanes 0-1, or all four lanes when 4 are active, then swing clamp
    function automatic t_levels apply_request(input logic [2:0] lc, input logic dt,
                                              input logic [15:0] req);
        t_levels    lv;
        logic [1:0] s;
        logic [1:0] e;
        logic [1:0] c;
        s = 2'd0;
        e = 2'd0;
        for (int i = 0; i < 4; i++) begin
            if (i < 2 || lc == 3'd4) begin
                if (req[4*i +: 2] > s) s = req[4*i +: 2];
                if (req[4*i+2 +: 2] > e) e = req[4*i+2 +: 2];
            end
        end
        c = swing_clamp(dt, e);
        if (s > c) s = c;
        lv.swing = s;
        lv.emph  = e;
        return lv;
    endfunction

    // buffer drive select lookup
    function automatic t_drive drive_map(input logic dt, input logic [1:0] s,
                                         input logic [1:0] e);
        t_drive d;
        d.valid = 1'b1;
        d.sel   = 4'd0;
        case ({s, e})
            4'd0:    d.sel = 4'd0;
            4'd1:    d.sel = 4'd1;
            4'd2:    d.sel = 4'd2;
            4'd3:    d.sel = 4'd3;
            4'd4:    d.sel = 4'd4;
            4'd5:    d.sel = 4'd5;
            4'd6:    d.sel = 4'd6;
            4'd8:    d.sel = 4'd7;
            4'd9:    d.sel = 4'd8;
            4'd12: begin
                d.valid = ~dt;
                d.sel   = dt ? 4'd0 : 4'd9;
            end
            default: d.valid = 1'b0;
        endcase
        return d;
    endfunction

endpackage

### rtl/core/dp_link_training_controller_top.sv
// channel   direction  signals                                    payload
// request   in         i_in_valid / o_in_ready                    i_in_data  (t_in_item)
// result    out        o_out_valid / i_out_ready                  o_out_data (t_out_item)
// config    in/out     psel penable pwrite paddr pwdata prdata pready
//
// each request is decided combinationally from the training state; its result is
// loaded into the output register at the accepting edge, one request per cycle unless the output stalls.
// a new request is taken whenever the output register is empty or being drained.
// synchronous active-low reset: phase idle, levels and counters zero,
// active lanes 4, drive_table 1, tps3_enable 0. pready is always high.
module dp_link_training_controller_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  dltc_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output dltc_pkg::t_out_item         o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dltc_pkg::ADDR_W-1:0] paddr,
    input  logic [dltc_pkg::DATA_W-1:0] pwdata,
    output logic [dltc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import dltc_pkg::*;

    logic [2:0]  r_active_lanes;
    logic        r_drive_table;
    logic        r_tps3_enable;

    t_phase      r_phase,      n_phase;
    logic [1:0]  r_swing,      n_swing;
    logic [1:0]  r_emph,       n_emph;
    logic        r_swing_max,  n_swing_max;
    logic        r_emph_max,   n_emph_max;
    logic [15:0] r_stored,     n_stored;
    logic [2:0]  r_repeat,     n_repeat;
    logic [2:0]  r_eq_tries,   n_eq_tries;

    logic        r_out_valid;
    t_out_item   r_out_data;
    t_out_item   n_out_data;

    logic        in_fire;
    logic        cfg_wr;
    t_reg_idx    cfg_idx;
    logic        cr_done;
    logic        eq_done;
    logic        same_req;
    logic [2:0]  rep_inc;
    logic [2:0]  try_inc;
    t_levels     lv_req;
    t_levels     lv_stored;
    t_drive      drv;
    logic [1:0]  eq_pat;

    assign pready     = 1'b1;
    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign in_fire    = i_in_valid & o_in_ready;
    assign cfg_wr     = psel & penable & pwrite;
    assign cfg_idx    = t_reg_idx'(paddr[3:2]);

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_lanes <= ACTIVE_LANES_RST;
            r_drive_table  <= DRIVE_TABLE_RST;
            r_tps3_enable  <= TPS3_ENABLE_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ACTIVE_LANES: r_active_lanes <= pwdata[2:0];
                REG_DRIVE_TABLE:  r_drive_table  <= pwdata[0];
                REG_TPS3_ENABLE:  r_tps3_enable  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // configuration read
    always_comb begin
        prdata = '0;
        case (cfg_idx)
            REG_ACTIVE_LANES: prdata = DATA_W'(r_active_lanes);
            REG_DRIVE_TABLE:  prdata = DATA_W'(r_drive_table);
            REG_TPS3_ENABLE:  prdata = DATA_W'(r_tps3_enable);
            default:          prdata = '0;
        endcase
    end

    // request decode
    assign cr_done   = lanes_match(r_active_lanes, i_in_data.lane_flags,
                                   CR_MASK_1, CR_MASK_2, CR_MASK_4);
    assign eq_done   = lanes_match(r_active_lanes, i_in_data.lane_flags,
                                   EQ_MASK_1, EQ_MASK_2, EQ_MASK_4);
    assign same_req  = (i_in_data.adjust_request == r_stored);
    assign rep_inc   = r_repeat + 3'd1;
    assign try_inc   = r_eq_tries + 3'd1;
    assign lv_req    = apply_request(r_active_lanes, r_drive_table, i_in_data.adjust_request);
    assign lv_stored = apply_request(r_active_lanes, r_drive_table, r_stored);
    assign eq_pat    = r_tps3_enable ? PAT_3 : PAT_2;

    // next training state
    always_comb begin
        n_phase     = r_phase;
        n_swing     = r_swing;
        n_emph      = r_emph;
        n_swing_max = r_swing_max;
        n_emph_max  = r_emph_max;
        n_stored    = r_stored;
        n_repeat    = r_repeat;
        n_eq_tries  = r_eq_tries;
        if (i_in_data.kind == KIND_START) begin
            n_phase     = PH_CR;
            n_swing     = 2'd0;
            n_emph      = 2'd0;
            n_swing_max = 1'b0;
            n_emph_max  = 1'b0;
            n_stored    = 16'd0;
            n_repeat    = 3'd0;
            n_eq_tries  = 3'd0;
        end else begin
            case (r_phase)
                PH_CR: begin
                    if (cr_done) begin
                        // levels come from the last stored request, flags recomputed
                        n_phase     = PH_EQ;
                        n_eq_tries  = 3'd0;
                        n_swing     = lv_stored.swing;
                        n_emph      = lv_stored.emph;
                        n_swing_max = (lv_stored.swing == swing_limit(r_drive_table));
                        n_emph_max  = (lv_stored.emph == emph_limit(r_drive_table));
                    end else begin
                        n_repeat = same_req ? rep_inc : 3'd0;
                        n_stored = i_in_data.adjust_request;
                        if (same_req && rep_inc > REPEAT_LIMIT) begin
                            n_phase = PH_FAIL;
                        end else if (r_swing_max) begin
                            n_phase = PH_FAIL;
                        end else begin
                            n_swing     = lv_req.swing;
                            n_emph      = lv_req.emph;
                            n_swing_max = r_swing_max |
                                          (lv_req.swing == swing_limit(r_drive_table));
                            n_emph_max  = r_emph_max |
                                          (lv_req.emph == emph_limit(r_drive_table));
                        end
                    end
                end
                PH_EQ: begin
                    if (!cr_done) begin
                        n_phase = PH_FAIL;
                    end else if (eq_done && i_in_data.align_ok) begin
                        n_phase = PH_PASS;
                    end else begin
                        n_eq_tries = try_inc;
                        if (try_inc > EQ_TRY_LIMIT) begin
                            n_phase = PH_FAIL;
                        end else begin
                            n_swing     = lv_req.swing;
                            n_emph      = lv_req.emph;
                            n_swing_max = r_swing_max |
                                          (lv_req.swing == swing_limit(r_drive_table));
                            n_emph_max  = r_emph_max |
                                          (lv_req.emph == emph_limit(r_drive_table));
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // result fields from the new state
    assign drv = drive_map(r_drive_table, n_swing, n_emph);

    always_comb begin
        n_out_data.lane_set     = {n_emph_max, n_emph, n_swing_max, n_swing};
        n_out_data.drive_valid  = drv.valid;
        n_out_data.drive_select = drv.valid ? drv.sel : 4'd0;
        case (n_phase)
            PH_CR: begin
                n_out_data.pattern = PAT_1;
                n_out_data.status  = STAT_TRAIN;
            end
            PH_EQ: begin
                n_out_data.pattern = eq_pat;
                n_out_data.status  = STAT_TRAIN;
            end
            PH_PASS: begin
                n_out_data.pattern = PAT_OFF;
                n_out_data.status  = STAT_PASS;
            end
            PH_FAIL: begin
                n_out_data.pattern = PAT_OFF;
                n_out_data.status  = STAT_FAIL;
            end
            default: begin
                n_out_data.pattern = PAT_OFF;
                n_out_data.status  = STAT_IDLE;
            end
        endcase
    end

    // training state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_swing     <= 2'd0;
            r_emph      <= 2'd0;
            r_swing_max <= 1'b0;
            r_emph_max  <= 1'b0;
            r_stored    <= 16'd0;
            r_repeat    <= 3'd0;
            r_eq_tries  <= 3'd0;
        end else if (in_fire) begin
            r_phase     <= n_phase;
            r_swing     <= n_swing;
            r_emph      <= n_emph;
            r_swing_max <= n_swing_max;
            r_emph_max  <= n_emph_max;
            r_stored    <= n_stored;
            r_repeat    <= n_repeat;
            r_eq_tries  <= n_eq_tries;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### rtl/core/dltc_checker.sv
module dltc_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        o_in_ready,
    input  dltc_pkg::t_in_item          i_in_data,
    input  logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  dltc_pkg::t_out_item         o_out_data
);
    import dltc_pkg::*;

    // every accepted request leaves a result behind
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted request produced no result");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // an empty output register never blocks a request
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

    // a start request opens clock recovery with pattern 1 at lowest drive
    a_start_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.kind == KIND_START) |=>
        (o_out_data.status == STAT_TRAIN && o_out_data.pattern == PAT_1 &&
         o_out_data.lane_set == 6'd0))
        else $error("start request gave wrong result");

endmodule

bind dp_link_training_controller_top dltc_checker u_dltc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
